// ===== design/cvbs_pkg.sv =====
// Shared constants and types for the convex volume box/sphere test.
package cvbs_pkg;

	localparam int MAX_PLANES      = 6;
	localparam int STAGES_PER_CELL = 3;
	localparam int PIPE_DEPTH      = MAX_PLANES * STAGES_PER_CELL;
	localparam int CNT_W           = $clog2(PIPE_DEPTH + 1);

	localparam int COORD_W  = 22;
	localparam int NORM_W   = 14;
	localparam int PROD_W   = COORD_W + NORM_W;
	localparam int ACC_W    = PROD_W + 5;
	localparam int FRAC_GAP = 12;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;
	localparam int ACT_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE0 = 3'd1;

	typedef struct packed {
		logic signed [COORD_W-1:0] offset;
		logic signed [NORM_W-1:0]  nz;
		logic signed [NORM_W-1:0]  ny;
		logic signed [NORM_W-1:0]  nx;
	} plane_t;

	typedef struct packed {
		logic                      sphere;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [COORD_W-1:0]        ex;
		logic [COORD_W-1:0]        ey;
		logic [COORD_W-1:0]        ez;
		logic signed [COORD_W-1:0] rad;
		logic                      hit;
		logic                      contained;
	} item_t;

	// plane register write into one cell
	typedef struct packed {
		logic   we;
		plane_t data;
	} plane_wr_t;

endpackage

// ===== design/cvbs_if.sv =====
// Request and response channel interfaces.
interface cvbs_req_if;
	import cvbs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic signed [COORD_W-1:0] center_z;
	logic signed [COORD_W-1:0] extent_x;
	logic signed [COORD_W-1:0] extent_y;
	logic signed [COORD_W-1:0] extent_z;
	logic signed [COORD_W-1:0] radius;

	modport source (output valid, req_type, center_x, center_y, center_z,
		extent_x, extent_y, extent_z, radius, input ready);
	modport sink (input valid, req_type, center_x, center_y, center_z,
		extent_x, extent_y, extent_z, radius, output ready);
endinterface

interface cvbs_rsp_if;
	logic valid;
	logic ready;
	logic intersects;
	logic fully_inside;

	modport source (output valid, intersects, fully_inside, input ready);
	modport sink (input valid, intersects, fully_inside, output ready);
endinterface

// ===== design/cvbs_cell.sv =====
// One plane cell: holds a plane, tests the passing word against it in three stages.
module cvbs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enable,
	input  cvbs_pkg::plane_wr_t plane_wr,
	input  logic               in_valid,
	output logic               in_ready,
	input  cvbs_pkg::item_t    in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cvbs_pkg::item_t    out_item
);
	import cvbs_pkg::*;

	plane_t plane_q;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	item_t item_s1, item_s2, item_s3;

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic [PROD_W-1:0]        ax_s1, ay_s1, az_s1;
	logic signed [ACC_W-1:0]  dist_s2, push_s2;

	logic [NORM_W-1:0]        anx, any, anz;
	logic signed [PROD_W-1:0] px_c, py_c, pz_c;
	logic [PROD_W-1:0]        ax_c, ay_c, az_c;
	logic signed [ACC_W-1:0]  dist_c, push_box_c, push_sph_c, push_c;
	logic                     gt_c, gt_neg_c;
	item_t                    item_c;

	// each stage moves when empty or when the next one moves
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (plane_wr.we) begin
			plane_q <= plane_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: products
	always_comb begin
		anx  = plane_q.nx[NORM_W-1] ? NORM_W'(-plane_q.nx) : NORM_W'(plane_q.nx);
		any  = plane_q.ny[NORM_W-1] ? NORM_W'(-plane_q.ny) : NORM_W'(plane_q.ny);
		anz  = plane_q.nz[NORM_W-1] ? NORM_W'(-plane_q.nz) : NORM_W'(plane_q.nz);
		px_c = PROD_W'(plane_q.nx) * PROD_W'(in_item.cx);
		py_c = PROD_W'(plane_q.ny) * PROD_W'(in_item.cy);
		pz_c = PROD_W'(plane_q.nz) * PROD_W'(in_item.cz);
		ax_c = PROD_W'(anx) * PROD_W'(in_item.ex);
		ay_c = PROD_W'(any) * PROD_W'(in_item.ey);
		az_c = PROD_W'(anz) * PROD_W'(in_item.ez);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= in_item;
			px_s1   <= px_c;
			py_s1   <= py_c;
			pz_s1   <= pz_c;
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			az_s1   <= az_c;
		end
	end

	// stage 2: distance and push-out, both at 12 fraction bits
	always_comb begin
		dist_c = ACC_W'(px_s1) + ACC_W'(py_s1) + ACC_W'(pz_s1)
			- (ACC_W'(plane_q.offset) <<< FRAC_GAP);
		push_box_c = ACC_W'(ax_s1) + ACC_W'(ay_s1) + ACC_W'(az_s1);
		push_sph_c = ACC_W'(item_s1.rad) <<< FRAC_GAP;
		push_c     = item_s1.sphere ? push_sph_c : push_box_c;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2 <= item_s1;
			dist_s2 <= dist_c;
			push_s2 <= push_c;
		end
	end

	// stage 3: fold this plane into the flags
	always_comb begin
		gt_c     = dist_s2 > push_s2;
		gt_neg_c = dist_s2 > -push_s2;
		item_c   = item_s2;
		if (enable) begin
			item_c.hit       = item_s2.hit & !gt_c;
			item_c.contained = item_s2.contained & !gt_c & !gt_neg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3 <= item_c;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

// ===== design/convex_volume_box_sphere_test.sv =====
// Throughput: one word per cycle while the response side is ready; each cell stage moves when it is empty or its
// successor moves, so bubbles are filled while a response waits.
// The chain length is fixed by the six plane cells, whatever the active-plane register holds.
// Reset (arst_n low, asynchronous) empties the pipeline and clears the plane and active-count registers.
// Top level: convex volume box/sphere test, a chain of plane cells.
module convex_volume_box_sphere_test (
	input  logic                             clk,
	input  logic                             arst_n,
	cvbs_req_if.sink                         req,
	cvbs_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [cvbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cvbs_pkg::CFG_W-1:0]       cfg_wdata
);
	import cvbs_pkg::*;

	logic [ACT_W-1:0] active_q;
	logic [ACT_W-1:0] count;

	logic  chain_v   [MAX_PLANES+1];
	logic  chain_rdy [MAX_PLANES+1];
	item_t chain_item[MAX_PLANES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we && cfg_index == REG_ACTIVE) begin
			active_q <= cfg_wdata[ACT_W-1:0];
		end
	end

	// counts above the cell count saturate
	assign count = (active_q > ACT_W'(MAX_PLANES)) ? ACT_W'(MAX_PLANES) : active_q;

	always_comb begin
		chain_item[0].sphere    = req.req_type;
		chain_item[0].cx        = req.center_x;
		chain_item[0].cy        = req.center_y;
		chain_item[0].cz        = req.center_z;
		chain_item[0].ex        = req.extent_x[COORD_W-1] ? COORD_W'(-req.extent_x)
			: COORD_W'(req.extent_x);
		chain_item[0].ey        = req.extent_y[COORD_W-1] ? COORD_W'(-req.extent_y)
			: COORD_W'(req.extent_y);
		chain_item[0].ez        = req.extent_z[COORD_W-1] ? COORD_W'(-req.extent_z)
			: COORD_W'(req.extent_z);
		chain_item[0].rad       = req.radius;
		chain_item[0].hit       = 1'b1;
		chain_item[0].contained = 1'b1;
	end

	assign chain_v[0] = req.valid;
	assign req.ready  = chain_rdy[0];

	for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
		plane_wr_t plane_wr;

		assign plane_wr.we   = cfg_we && (cfg_index == CFG_IDX_W'(REG_PLANE0 + i));
		assign plane_wr.data = cfg_wdata;

		cvbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.enable   (ACT_W'(i) < count),
			.plane_wr (plane_wr),
			.in_valid (chain_v[i]),
			.in_ready (chain_rdy[i]),
			.in_item  (chain_item[i]),
			.out_valid(chain_v[i+1]),
			.out_ready(chain_rdy[i+1]),
			.out_item (chain_item[i+1])
		);
	end

	assign rsp.valid             = chain_v[MAX_PLANES];
	assign rsp.intersects        = chain_item[MAX_PLANES].hit;
	assign rsp.fully_inside      = chain_item[MAX_PLANES].contained;
	assign chain_rdy[MAX_PLANES] = rsp.ready;

endmodule

// ===== design/cvbs_checker.sv =====
// Port-level checks for the convex volume test, bound to the top level.
module cvbs_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic intersects,
	input logic fully_inside
);
	import cvbs_pkg::*;

	logic [CNT_W-1:0] pend_q;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CNT_W'(req_valid && req_ready) - CNT_W'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(intersects) && $stable(fully_inside))
		else $error("response word dropped or changed while stalled");

	a_inside_hits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> intersects || !fully_inside)
		else $error("fully_inside set on a word that does not intersect");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != '0)
		else $error("response word with no request outstanding");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

endmodule

bind convex_volume_box_sphere_test cvbs_checker u_cvbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.intersects  (rsp.intersects),
	.fully_inside(rsp.fully_inside)
);

// ===== tb/tb_convex_volume_box_sphere_test.sv =====
// Testbench for the convex volume box/sphere test: random and directed words, scoreboard check.
module tb_convex_volume_box_sphere_test;
	import cvbs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int CMAX = (1 << (COORD_W - 1)) - 1;
	localparam int CMIN = -(1 << (COORD_W - 1));
	localparam int UNIT = 1 << FRAC_GAP;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic                      sphere;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic signed [COORD_W-1:0] ez;
		logic signed [COORD_W-1:0] rad;
	} bound_t;

	typedef struct packed {
		logic hit;
		logic contained;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	cvbs_req_if req_ch ();
	cvbs_rsp_if rsp_ch ();

	convex_volume_box_sphere_test i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow of the register file, as the block should hold it
	logic [ACT_W-1:0] vol_active;
	plane_t           vol_planes [MAX_PLANES];
	plane_t           staged     [MAX_PLANES];

	bound_t   pending_bounds [$];
	verdict_t expected_verdicts [$];
	bound_t   on_bus;

	int  n_queued, n_sent, n_checked, n_errors, n_settings;
	int  n_outside, n_straddle, n_inside;
	int  send_pause, recv_pause;
	bit  no_idle;
	longint cycles;

	function automatic verdict_t cull_verdict(input bound_t b);
		verdict_t v;
		longint cx, cy, cz, ex, ey, ez, rad, nx, ny, nz, w, sdist, push;
		int n;
		v.hit = 1'b1;
		v.contained = 1'b1;
		cx = b.cx; cy = b.cy; cz = b.cz; rad = b.rad;
		ex = b.ex; ey = b.ey; ez = b.ez;
		ex = ex < 0 ? -ex : ex;
		ey = ey < 0 ? -ey : ey;
		ez = ez < 0 ? -ez : ez;
		n = vol_active > MAX_PLANES ? MAX_PLANES : vol_active;
		for (int i = 0; i < n; i++) begin
			nx = vol_planes[i].nx;
			ny = vol_planes[i].ny;
			nz = vol_planes[i].nz;
			w  = vol_planes[i].offset;
			sdist = nx * cx + ny * cy + nz * cz - w * UNIT;
			if (b.sphere)
				push = rad * UNIT;
			else
				push = ex * (nx < 0 ? -nx : nx) + ey * (ny < 0 ? -ny : ny)
					+ ez * (nz < 0 ? -nz : nz);
			if (sdist > push) begin
				v.hit = 1'b0;
				v.contained = 1'b0;
				break;
			end
			if (sdist > -push)
				v.contained = 1'b0;
		end
		return v;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return COORD_W'($urandom);
		if (r < 85)
			return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
		case ($urandom_range(0, 3))
			0: return COORD_W'(CMAX);
			1: return COORD_W'(CMIN);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic bound_t rand_bound();
		bound_t b;
		b.sphere = $urandom_range(0, 1);
		b.cx = rand_coord(); b.cy = rand_coord(); b.cz = rand_coord();
		b.ex = rand_coord(); b.ey = rand_coord(); b.ez = rand_coord();
		b.rad = rand_coord();
		return b;
	endfunction

	// plane 0 is the x axis in directed tests, so y, z and unused sizes are free
	function automatic bound_t aimed(input bit sphere, input int c, input int s);
		bound_t b;
		b = rand_bound();
		b.sphere = sphere;
		b.cx = COORD_W'(c);
		if (sphere)
			b.rad = COORD_W'(s);
		else
			b.ex = COORD_W'(s);
		return b;
	endfunction

	function automatic plane_t make_plane();
		plane_t p;
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 3) begin
			p = {$urandom, $urandom};
		end else if (k < 9) begin
			p.nx = $urandom_range(0, 1) ? NORM_W'(int'($urandom_range(0, 8192)) - 4096) : '0;
			p.ny = $urandom_range(0, 1) ? NORM_W'(int'($urandom_range(0, 8192)) - 4096) : '0;
			p.nz = $urandom_range(0, 1) ? NORM_W'(int'($urandom_range(0, 8192)) - 4096) : '0;
			p.offset = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
		end else begin
			case ($urandom_range(0, 3))
				0: p = '1;
				1: p = '0;
				2: p = {1'b0, {(COORD_W-1){1'b1}}, {3{1'b0, {(NORM_W-1){1'b1}}}}};
				default: p = {1'b1, {(COORD_W-1){1'b0}}, {3{1'b1, {(NORM_W-1){1'b0}}}}};
			endcase
		end
		return p;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_ACTIVE)
			vol_active = data[ACT_W-1:0];
		else if (idx >= REG_PLANE0 && idx < REG_PLANE0 + MAX_PLANES)
			vol_planes[idx - REG_PLANE0] = data;
	endtask

	// every register, plus a stray write to the unmapped index
	task automatic apply_config(input logic [ACT_W-1:0] act);
		write_reg(REG_NONE, {$urandom, $urandom});
		for (int i = 0; i < MAX_PLANES; i++)
			write_reg(REG_PLANE0 + CFG_IDX_W'(i), staged[i]);
		write_reg(REG_ACTIVE, {{(CFG_W-ACT_W){1'b1}}, act});
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		repeat (2) @(posedge clk);
	endtask

	task automatic queue_bound(input bound_t b);
		pending_bounds.push_back(b);
		n_queued++;
	endtask

	task automatic drain();
		while (n_sent != n_queued || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_pause   <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_verdicts.push_back(cull_verdict(on_bus));
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_pause > 0) begin
					send_pause   <= send_pause - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_bounds.size() > 0) begin
					on_bus = pending_bounds.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.req_type <= on_bus.sphere;
					req_ch.center_x <= on_bus.cx;
					req_ch.center_y <= on_bus.cy;
					req_ch.center_z <= on_bus.cz;
					req_ch.extent_x <= on_bus.ex;
					req_ch.extent_y <= on_bus.ey;
					req_ch.extent_z <= on_bus.ez;
					req_ch.radius   <= on_bus.rad;
					send_pause      <= pick_pause();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_pause   <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("response word with nothing expected");
					n_errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (rsp_ch.intersects !== want.hit) begin
						$error("intersects: expected %0b, got %0b", want.hit, rsp_ch.intersects);
						n_errors++;
					end
					if (rsp_ch.fully_inside !== want.contained) begin
						$error("fully_inside: expected %0b, got %0b", want.contained,
							rsp_ch.fully_inside);
						n_errors++;
					end
					n_checked++;
					if (!want.hit)
						n_outside++;
					else if (want.contained)
						n_inside++;
					else
						n_straddle++;
				end
			end
			if (recv_pause > 0) begin
				recv_pause   <= recv_pause - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				recv_pause   <= pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles,
				expected_verdicts.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.center_x = '0;
		req_ch.center_y = '0;
		req_ch.center_z = '0;
		req_ch.extent_x = '0;
		req_ch.extent_y = '0;
		req_ch.extent_z = '0;
		req_ch.radius = '0;
		rsp_ch.ready = 1'b0;
		vol_active = '0;
		for (int i = 0; i < MAX_PLANES; i++)
			vol_planes[i] = '0;
		no_idle = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset state: no planes, everything inside
		repeat (4)
			queue_bound(rand_bound());
		drain();

		// one plane on x, through the origin: boundaries are exact
		for (int i = 0; i < MAX_PLANES; i++)
			staged[i] = '0;
		staged[0].nx = NORM_W'(UNIT);
		apply_config(1);
		queue_bound(aimed(1'b0, 16, 16));     // touching from outside
		queue_bound(aimed(1'b0, -16, 16));    // touching from inside
		queue_bound(aimed(1'b0, 17, 16));
		queue_bound(aimed(1'b0, 0, 0));
		queue_bound(aimed(1'b1, 32, 32));
		queue_bound(aimed(1'b1, -32, 32));
		queue_bound(aimed(1'b1, 33, 32));
		queue_bound(aimed(1'b1, -20, -16));   // negative radius taken as given
		queue_bound(aimed(1'b1, -10, -16));
		queue_bound(aimed(1'b0, CMIN, CMIN)); // most negative extent
		queue_bound(aimed(1'b0, CMAX, CMIN));
		queue_bound(aimed(1'b0, CMAX, CMAX));
		queue_bound(aimed(1'b1, CMAX, CMAX));
		queue_bound(aimed(1'b1, CMIN, CMIN));
		queue_bound(aimed(1'b1, CMAX, CMIN));
		drain();

		// count above the plane limit saturates
		for (int i = 0; i < MAX_PLANES; i++)
			staged[i] = make_plane();
		apply_config(7);
		repeat (6)
			queue_bound(rand_bound());
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			for (int i = 0; i < MAX_PLANES; i++)
				staged[i] = make_plane();
			no_idle = (ph % 4 == 3);
			case (ph)
				0: apply_config(MAX_PLANES);
				1: apply_config(0);
				2: apply_config(7);
				default: apply_config($urandom_range(0, 7));
			endcase
			repeat (50)
				queue_bound(rand_bound());
			drain();
		end

		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("checked %0d result words over %0d plane settings", n_checked, n_settings);
		$display("outside %0d, straddling %0d, fully inside %0d", n_outside, n_straddle,
			n_inside);
		if (n_errors == 0 && expected_verdicts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
